// ===== rtl/vadt_pkg.sv =====
// Shared types and codes of the vertex attribute deduplication table.
`timescale 1ns / 1ps

package vadt_pkg;

  localparam int unsigned IDX_W = 12;
  localparam int unsigned PC_W  = 13;
  localparam int unsigned ST_W  = 2;

  localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [ST_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [ST_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0] position_index;
    logic [IDX_W-1:0] texture_index;
    logic [IDX_W-1:0] normal_index;
  } vadt_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             made_duplicate;
    logic [ST_W-1:0]  status;
  } vadt_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_CHECK,
    ST_APPEND,
    ST_LINK,
    ST_DONE
  } vadt_state_e;

endpackage

// ===== rtl/vadt_mem.sv =====
// Single write, single registered read vertex table memory.
`timescale 1ns / 1ps

module vadt_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned WORD_W = 37
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WORD_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WORD_W-1:0]        rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vadt_ctrl.sv =====
// Sequencer that walks duplicate chains and appends new duplicates to the table.
`timescale 1ns / 1ps

module vadt_ctrl import vadt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  vadt_in_t         in_item_i,
  input  logic             cfg_we_i,
  input  logic [PC_W-1:0]  cfg_data_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output vadt_out_t        res_o
);

  localparam int unsigned IW     = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW     = (IW + 1 > PC_W) ? IW + 1 : PC_W;
  localparam int unsigned WORD_W = 1 + 2 * IDX_W + IW;

  localparam logic [CW-1:0] TE     = CW'(TABLE_ENTRIES);
  localparam logic [CW:0]   TE_EXT = (CW + 1)'(TABLE_ENTRIES);

  vadt_state_e state_q, state_d;

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [IW-1:0]    dup_q, dup_d;
  logic [IW-1:0]    clr_q, clr_d;
  logic [IW-1:0]    cur_q, cur_d;
  logic [IW-1:0]    fresh_q, fresh_d;
  logic             first_q, first_d;
  logic [IDX_W-1:0] tex_q, tex_d;
  logic [IDX_W-1:0] nrm_q, nrm_d;
  vadt_out_t        res_q, res_d;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [WORD_W-1:0] mem_rdata;

  logic             rd_valid;
  logic [IDX_W-1:0] rd_tex;
  logic [IDX_W-1:0] rd_nrm;
  logic [IW-1:0]    rd_link;

  logic [CW-1:0] pc_ext;
  logic [CW-1:0] pce;
  logic [CW-1:0] pce_new;
  logic [CW:0]   fresh_sum;
  logic          accept;

  vadt_mem #(
    .DEPTH  (TABLE_ENTRIES),
    .WORD_W (WORD_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cur_q),
    .rdata_o (mem_rdata)
  );

  assign {rd_valid, rd_tex, rd_nrm, rd_link} = mem_rdata;

  assign pc_ext    = CW'(pc_q);
  assign pce       = (pc_ext > TE) ? TE : pc_ext;
  assign pce_new   = (CW'(cfg_data_i) > TE) ? TE : CW'(cfg_data_i);
  assign fresh_sum = {1'b0, pce} + (CW + 1)'(dup_q);

  assign in_stall_o  = (state_q != ST_IDLE) || cfg_we_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      dup_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      dup_q   <= dup_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    fresh_q <= fresh_d;
    first_q <= first_d;
    tex_q   <= tex_d;
    nrm_q   <= nrm_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    dup_d     = dup_q;
    clr_d     = clr_q;
    cur_d     = cur_q;
    fresh_d   = fresh_q;
    first_d   = first_q;
    tex_d     = tex_q;
    nrm_d     = nrm_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = {1'b1, tex_q, nrm_q, {IW{1'b0}}};
    mem_re    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          tex_d   = in_item_i.texture_index;
          nrm_d   = in_item_i.normal_index;
          cur_d   = IW'(in_item_i.position_index);
          first_d = 1'b1;
          if (CW'(in_item_i.position_index) >= pce) begin
            res_d   = '{vertex_index: '0, made_duplicate: 1'b0, status: STATUS_RANGE};
            state_d = ST_DONE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IW'(1);
        if ((CW'(clr_q) + CW'(1)) == pce) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        fresh_d = IW'(fresh_sum);
        if (first_q && !rd_valid) begin
          mem_we  = 1'b1;
          res_d   = '{vertex_index: IDX_W'(cur_q), made_duplicate: 1'b0, status: STATUS_OK};
          state_d = ST_DONE;
        end else if (rd_tex == tex_q && rd_nrm == nrm_q) begin
          res_d   = '{vertex_index: IDX_W'(cur_q), made_duplicate: 1'b0, status: STATUS_OK};
          state_d = ST_DONE;
        end else if (rd_link != '0) begin
          cur_d   = rd_link;
          first_d = 1'b0;
          state_d = ST_READ;
        end else if (fresh_sum >= TE_EXT) begin
          res_d   = '{vertex_index: '0, made_duplicate: 1'b0, status: STATUS_FULL};
          state_d = ST_DONE;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = fresh_q;
        state_d   = ST_LINK;
      end
      ST_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = {rd_valid, rd_tex, rd_nrm, fresh_q};
        dup_d     = dup_q + IW'(1);
        res_d     = '{vertex_index: IDX_W'(fresh_q), made_duplicate: 1'b1, status: STATUS_OK};
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      pc_d    = cfg_data_i;
      dup_d   = '0;
      clr_d   = '0;
      mem_we  = 1'b0;
      state_d = (pce_new == '0) ? ST_IDLE : ST_CLEAR;
    end
  end

endmodule

// ===== rtl/vertex_attribute_dedup_table_unit.sv =====
// Top level of the vertex attribute deduplication table with its output register.
`timescale 1ns / 1ps

// Each item is one face corner and yields one result item with the chosen table
// entry. The block takes one item at a time in a sequencer around a table memory
// with one write port and one registered read port: a corner whose position is new
// or whose original entry matches passes through a read, a check and the done state
// before the input is free again, every further link followed along the duplicate
// chain adds one memory read and one compare, and appending a new duplicate adds
// its two table writes. A corner with an out-of-range position goes straight from
// idle to the done state. A result waits in the output register while the next item is taken.
// Every write of position_count starts a clearing pass over the first
// min(position_count, TABLE_ENTRIES) table entries, one per cycle, during which
// no item is accepted.
module vertex_attribute_dedup_table_unit import vadt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  vadt_in_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output vadt_out_t       out_item_o,
  input  logic            cfg_we_i,
  input  logic [PC_W-1:0] cfg_data_i
);

  logic      res_valid;
  logic      res_ready;
  vadt_out_t res;
  logic      out_valid_q, out_valid_d;
  vadt_out_t out_item_q;

  vadt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== tb/sv/vadt_index_checker.sv =====
// Checker that predicts and compares the vertex index, duplicate flag and status of every face corner.
`timescale 1ns / 1ps

module vadt_index_checker import vadt_pkg::*; #(
  parameter int unsigned ENTRIES = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  vadt_in_t        in_item_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  vadt_out_t       out_item_i,
  input  logic            cfg_we_i,
  input  logic [PC_W-1:0] cfg_data_i,
  output int              pending_o,
  output int              fail_count_o,
  output int              dup_count_o,
  output int              range_count_o,
  output int              full_count_o
);

  logic [PC_W-1:0]  mesh_positions;
  bit               slot_used [ENTRIES];
  logic [IDX_W-1:0] slot_tex  [ENTRIES];
  logic [IDX_W-1:0] slot_nrm  [ENTRIES];
  logic [PC_W-1:0]  slot_link [ENTRIES];
  int unsigned      extra_slots;
  vadt_out_t        awaited_vertices[$];
  int               mismatches;
  int               dup_seen;
  int               range_seen;
  int               full_seen;

  assign fail_count_o  = mismatches;
  assign dup_count_o   = dup_seen;
  assign range_count_o = range_seen;
  assign full_count_o  = full_seen;

  task automatic wipe_table();
    for (int k = 0; k < ENTRIES; k++) begin
      slot_used[k] = 1'b0;
    end
    extra_slots = 0;
  endtask

  function automatic void claim_slot(input int unsigned at, input logic [IDX_W-1:0] tex,
                                     input logic [IDX_W-1:0] nrm);
    slot_used[at] = 1'b1;
    slot_tex[at]  = tex;
    slot_nrm[at]  = nrm;
    slot_link[at] = '0;
  endfunction

  function automatic vadt_out_t resolve_corner(input vadt_in_t c);
    vadt_out_t       r;
    int unsigned     limit;
    int unsigned     at;
    int unsigned     fresh;
    logic [PC_W-1:0] link;
    r        = '0;
    r.status = STATUS_OK;
    limit    = (mesh_positions > ENTRIES) ? ENTRIES : mesh_positions;
    if (c.position_index >= limit) begin
      r.status = STATUS_RANGE;
      return r;
    end
    if (!slot_used[c.position_index]) begin
      claim_slot(c.position_index, c.texture_index, c.normal_index);
      r.vertex_index = c.position_index;
      return r;
    end
    at = c.position_index;
    for (int hops = 0; hops < ENTRIES; hops++) begin
      if (slot_tex[at] == c.texture_index && slot_nrm[at] == c.normal_index) begin
        r.vertex_index = IDX_W'(at);
        return r;
      end
      link = slot_link[at];
      if (link == 0 || link >= ENTRIES || !slot_used[link]) begin
        fresh = limit + extra_slots;
        if (fresh >= ENTRIES) begin
          r.status = STATUS_FULL;
          return r;
        end
        claim_slot(fresh, c.texture_index, c.normal_index);
        slot_link[at]    = PC_W'(fresh);
        extra_slots      = extra_slots + 1;
        r.vertex_index   = IDX_W'(fresh);
        r.made_duplicate = 1'b1;
        return r;
      end
      at = link;
    end
    r.status = STATUS_FULL;
    return r;
  endfunction

  task automatic report(input string field, input logic [15:0] want, input logic [15:0] got);
    $display("%0t: corner result %s expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  initial begin
    mesh_positions = '0;
    mismatches     = 0;
    dup_seen       = 0;
    range_seen     = 0;
    full_seen      = 0;
    wipe_table();
  end

  always @(posedge clk_i) begin
    vadt_out_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        mesh_positions = cfg_data_i;
        wipe_table();
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_vertices.size() == 0) begin
          $display("%0t: result with none expected: vertex %0d, duplicate %0b, status %0d",
                   $time, out_item_i.vertex_index, out_item_i.made_duplicate,
                   out_item_i.status);
          mismatches++;
        end else begin
          want = awaited_vertices.pop_front();
          if (out_item_i.vertex_index !== want.vertex_index)
            report("vertex_index", want.vertex_index, out_item_i.vertex_index);
          if (out_item_i.made_duplicate !== want.made_duplicate)
            report("made_duplicate", want.made_duplicate, out_item_i.made_duplicate);
          if (out_item_i.status !== want.status)
            report("status", want.status, out_item_i.status);
          if (want.made_duplicate) dup_seen++;
          if (want.status == STATUS_RANGE) range_seen++;
          if (want.status == STATUS_FULL) full_seen++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_vertices.insert(awaited_vertices.size(), resolve_corner(in_item_i));
      end
    end
    pending_o <= awaited_vertices.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the testbench: clock, reset, corner stimulus, result stalls and the verdict.
`timescale 1ns / 1ps

module testbench import vadt_pkg::*;;

  localparam int unsigned ENTRIES     = 4096;
  localparam int          QUIET_LIMIT = 20000;
  localparam int          PHASE_ITEMS = 145;

  logic            clk_i    = 1'b0;
  logic            rst_ni   = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  vadt_in_t        in_item  = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  vadt_out_t       out_item;
  logic            cfg_we   = 1'b0;
  logic [PC_W-1:0] cfg_data = '0;

  int pending;
  int fail_count;
  int dup_count;
  int range_count;
  int full_count;
  int corners_sent = 0;
  int settings     = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;
  bit calm         = 1'b0;

  always #1 clk_i = ~clk_i;

  vertex_attribute_dedup_table_unit #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  vadt_index_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .dup_count_o  (dup_count),
    .range_count_o(range_count),
    .full_count_o (full_count)
  );

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic vadt_in_t corner(input int unsigned p, input int unsigned t,
                                      input int unsigned n);
    vadt_in_t c;
    c.position_index = IDX_W'(p);
    c.texture_index  = IDX_W'(t);
    c.normal_index   = IDX_W'(n);
    return c;
  endfunction

  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      stall_left = draw_gap();
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_corner(input vadt_in_t c);
    int gap;
    gap = draw_gap();
    if (gap == 0) begin
      in_valid <= 1'b1;
      in_item  <= c;
    end else begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      in_valid <= 1'b1;
      in_item  <= c;
    end
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    corners_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_positions(input int unsigned count);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= PC_W'(count);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned      limit;
    int unsigned      hot [8];
    logic [IDX_W-1:0] tex_pool [3];
    logic [IDX_W-1:0] nrm_pool [3];
    vadt_in_t         c;
    limit = (count > ENTRIES) ? ENTRIES : count;
    for (int k = 0; k < 8; k++) begin
      hot[k] = (limit == 0) ? 0 : $urandom_range(0, limit - 1);
    end
    for (int k = 0; k < 3; k++) begin
      tex_pool[k] = IDX_W'($urandom_range(0, 4095));
      nrm_pool[k] = IDX_W'($urandom_range(0, 4095));
    end
    set_positions(count);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == PHASE_ITEMS / 2) drain();
      if (limit == 0 || $urandom_range(0, 6) == 0) begin
        c.position_index = IDX_W'($urandom_range(0, 4095));
      end else begin
        c.position_index = IDX_W'(hot[$urandom_range(0, 7)]);
      end
      c.texture_index = ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, 4095))
                                                    : tex_pool[$urandom_range(0, 2)];
      c.normal_index  = ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, 4095))
                                                    : nrm_pool[$urandom_range(0, 2)];
      send_corner(c);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_corner(corner(0, 0, 0));
    send_corner(corner(4095, 4095, 4095));

    set_positions(4);
    send_corner(corner(0, 0, 0));
    send_corner(corner(0, 0, 0));
    send_corner(corner(0, 4095, 4095));
    send_corner(corner(0, 4095, 4095));
    send_corner(corner(0, 1, 0));
    send_corner(corner(0, 1, 0));
    send_corner(corner(3, 7, 9));
    send_corner(corner(4, 0, 0));

    set_positions(4096);
    send_corner(corner(4095, 5, 5));
    send_corner(corner(4095, 6, 6));
    send_corner(corner(4095, 5, 5));

    set_positions(8191);
    send_corner(corner(4095, 1, 2));
    send_corner(corner(4095, 2, 1));

    set_positions(4094);
    send_corner(corner(0, 0, 0));
    send_corner(corner(0, 1, 1));
    send_corner(corner(0, 2, 2));
    send_corner(corner(0, 3, 3));
    send_corner(corner(0, 2, 2));
    send_corner(corner(4094, 0, 0));

    random_phase(1);
    random_phase(7);
    random_phase(16);
    random_phase(64);
    random_phase(4096);
    random_phase(4060);
    random_phase(0);
    random_phase(300);
    random_phase(8191);
    random_phase(4095);
    random_phase(2);

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d face corners over %0d position_count settings.",
             corners_sent, settings);
    $display("Seen %0d new duplicates, %0d out-of-range positions, %0d full-table refusals.",
             dup_count, range_count, full_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/vadt_pkg.sv
rtl/vadt_mem.sv
rtl/vadt_ctrl.sv
rtl/vertex_attribute_dedup_table_unit.sv
tb/sv/vadt_index_checker.sv
tb/sv/testbench.sv
